FILE: sv/gpfl_pkg.sv
// Shared types, constants and helpers of the grid potential force lookup block.
`timescale 1ns / 1ps
`default_nettype none
package gpfl_pkg;

   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 256;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS);

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int DIM_W    = 9;
   localparam int PADDR_W  = 5;
   localparam int CSR_IDX_W = 3;

   // Front products: 33-bit difference times 32-bit factor.
   localparam int PROD_W   = 65;
   localparam int Q_W      = PROD_W - FRAC_W;
   localparam int IDX_W    = Q_W - FRAC_W;

   // Back stencil arithmetic.
   localparam int WGT_W      = 20;
   localparam int TAP_PROD_W = WGT_W + DATA_W;
   localparam int ACC_W      = 56;
   localparam int DIV_SHIFT  = 18;
   localparam int A_W        = ACC_W - DIV_SHIFT;
   localparam int NUM_W      = 40;
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = NUM_W / DIV_BITS;
   localparam int T_W        = A_W + 1;
   localparam int HI_W       = T_W - FRAC_W;
   localparam int PLO_W      = FRAC_W + 1 + DATA_W;
   localparam int PHI_W      = HI_W + DATA_W;
   localparam int FRC_W      = PHI_W + 1;
   localparam int NUM_TAPS   = 9;
   localparam int CENTER_TAP = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN    = 3'd0,
      CSR_Y_ORIGIN    = 3'd1,
      CSR_INV_STEP_X  = 3'd2,
      CSR_INV_STEP_Y  = 3'd3,
      CSR_WIDTH_USED  = 3'd4,
      CSR_HEIGHT_USED = 3'd5,
      CSR_VALUE_SCALE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_origin;
      logic signed [DATA_W-1:0] y_origin;
      logic signed [DATA_W-1:0] inv_x;
      logic signed [DATA_W-1:0] inv_y;
      logic signed [DATA_W-1:0] scale;
      logic [DIM_W-1:0]         width_used;
      logic [DIM_W-1:0]         height_used;
   } cfg_type;

   typedef enum logic [1:0] {
      ENT_WRITE,
      ENT_OUTSIDE,
      ENT_INSIDE
   } ent_kind_type;

   typedef struct packed {
      ent_kind_type             kind;
      logic [ADDR_W-1:0]        addr;
      logic [DATA_W-1:0]        wdata;
      logic [COL_W-1:0]         ix;
      logic [ROW_W-1:0]         iy;
      logic signed [FRAC_W-1:0] fx;
      logic signed [FRAC_W-1:0] fy;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_MUL,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_DRAIN,
      BK_DIV,
      BK_SCALE_A,
      BK_SCALE_B,
      BK_OUT
   } bk_state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi_lim;
      logic signed [63:0] lo_lim;
      hi_lim = 64'sh0000_0000_7FFF_FFFF;
      lo_lim = -64'sh0000_0000_8000_0000;
      if (v > hi_lim) begin
         sat32 = hi_lim[DATA_W-1:0];
      end else if (v < lo_lim) begin
         sat32 = lo_lim[DATA_W-1:0];
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

FILE: sv/gpfl_csr.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none
module gpfl_csr import gpfl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]       prdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   logic    wr_en;
   csr_index_type idx;

   assign wr_en = psel && penable && pwrite;
   assign idx   = csr_index_type'(paddr[PADDR_W-1:2]);
   assign cfg   = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin    <= '0;
         cfg_ff.y_origin    <= '0;
         cfg_ff.inv_x       <= 32'sh0001_0000;
         cfg_ff.inv_y       <= 32'sh0001_0000;
         cfg_ff.width_used  <= 9'd256;
         cfg_ff.height_used <= 9'd256;
         cfg_ff.scale       <= 32'sh0001_0000;
      end else if (wr_en) begin
         case (idx)
            CSR_X_ORIGIN:    cfg_ff.x_origin    <= pwdata;
            CSR_Y_ORIGIN:    cfg_ff.y_origin    <= pwdata;
            CSR_INV_STEP_X:  cfg_ff.inv_x       <= pwdata;
            CSR_INV_STEP_Y:  cfg_ff.inv_y       <= pwdata;
            CSR_WIDTH_USED:  cfg_ff.width_used  <= pwdata[DIM_W-1:0];
            CSR_HEIGHT_USED: cfg_ff.height_used <= pwdata[DIM_W-1:0];
            CSR_VALUE_SCALE: cfg_ff.scale       <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_X_ORIGIN:    prdata = cfg_ff.x_origin;
         CSR_Y_ORIGIN:    prdata = cfg_ff.y_origin;
         CSR_INV_STEP_X:  prdata = cfg_ff.inv_x;
         CSR_INV_STEP_Y:  prdata = cfg_ff.inv_y;
         CSR_WIDTH_USED:  prdata = DATA_W'(cfg_ff.width_used);
         CSR_HEIGHT_USED: prdata = DATA_W'(cfg_ff.height_used);
         CSR_VALUE_SCALE: prdata = cfg_ff.scale;
         default:         prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/gpfl_front.sv
// Front end: accepts items, scales writes, locates and classifies queries.
`timescale 1ns / 1ps
`default_nettype none
module gpfl_front import gpfl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [7:0]         req_col,
   input  wire logic [7:0]         req_row,
   input  wire logic [DATA_W-1:0]  req_pixel_value,
   input  wire logic [DATA_W-1:0]  req_pos_x,
   input  wire logic [DATA_W-1:0]  req_pos_y,
   input  q_status_type            q_stat,
   output logic                    q_push,
   output entry_type               q_data
);

   fe_state_type st_ff, st_in;
   logic                     cmd_ff;
   logic [7:0]               col_ff, row_ff;
   logic signed [DATA_W-1:0] a_ff, b_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff;

   logic                     accept;
   logic signed [DATA_W:0]   dx, dy, op_a;
   logic signed [DATA_W-1:0] op_b;
   logic signed [Q_W-1:0]    qx, qy;
   logic signed [IDX_W-1:0]  ix_w, iy_w, nx, ny, lim_x, lim_y;
   logic                     in_band;
   logic signed [PROD_W-1:0] wv;
   logic signed [Q_W-1:0]    wsh;
   logic                     write_ok;

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         FE_IDLE: if (req_valid) st_in = FE_MUL;
         FE_MUL:  st_in = FE_PUSH;
         FE_PUSH: if (!q_stat.full) st_in = FE_IDLE;
         default: st_in = FE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (st_ff == FE_IDLE);
      q_push    = (st_ff == FE_PUSH) && !q_stat.full && ((cmd_ff == CMD_QUERY) || write_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= FE_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         col_ff <= req_col;
         row_ff <= req_row;
         a_ff   <= (req_cmd == CMD_QUERY) ? req_pos_x : req_pixel_value;
         b_ff   <= req_pos_y;
      end
   end

   // Position offsets are exact in 33 bits.
   assign dx = $signed({a_ff[DATA_W-1], a_ff}) -
               $signed({cfg.x_origin[DATA_W-1], cfg.x_origin});
   assign dy = $signed({b_ff[DATA_W-1], b_ff}) -
               $signed({cfg.y_origin[DATA_W-1], cfg.y_origin});
   assign op_a = (cmd_ff == CMD_QUERY) ? dx : $signed({a_ff[DATA_W-1], a_ff});
   assign op_b = (cmd_ff == CMD_QUERY) ? cfg.inv_x : cfg.scale;

   always_ff @(posedge clock) begin
      if (st_ff == FE_MUL) begin
         px_ff <= op_a * op_b;
         py_ff <= dy * cfg.inv_y;
      end
   end

   // Nearest index and centered fraction.
   assign qx   = $signed(px_ff[PROD_W-1:FRAC_W]) + Q_W'(32768);
   assign qy   = $signed(py_ff[PROD_W-1:FRAC_W]) + Q_W'(32768);
   assign ix_w = $signed(qx[Q_W-1:FRAC_W]);
   assign iy_w = $signed(qy[Q_W-1:FRAC_W]);

   assign nx = (int'(cfg.width_used) > MAX_COLS) ? IDX_W'(MAX_COLS) : IDX_W'(cfg.width_used);
   assign ny = (int'(cfg.height_used) > MAX_ROWS) ? IDX_W'(MAX_ROWS) : IDX_W'(cfg.height_used);
   assign lim_x = nx - IDX_W'(2);
   assign lim_y = ny - IDX_W'(2);
   assign in_band = (ix_w >= IDX_W'(1)) && (ix_w <= lim_x) &&
                    (iy_w >= IDX_W'(1)) && (iy_w <= lim_y);

   // Write value: round half up, then saturate.
   assign wv  = px_ff + PROD_W'(32768);
   assign wsh = $signed(wv[PROD_W-1:FRAC_W]);
   assign write_ok = (int'(col_ff) < MAX_COLS) && (int'(row_ff) < MAX_ROWS);

   always_comb begin
      q_data       = '0;
      q_data.fx    = {~qx[FRAC_W-1], qx[FRAC_W-2:0]};
      q_data.fy    = {~qy[FRAC_W-1], qy[FRAC_W-2:0]};
      q_data.ix    = ix_w[COL_W-1:0];
      q_data.iy    = iy_w[ROW_W-1:0];
      q_data.addr  = ADDR_W'(row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(col_ff);
      q_data.wdata = sat32(64'(wsh));
      if (cmd_ff == CMD_WRITE) begin
         q_data.kind = ENT_WRITE;
      end else if (in_band) begin
         q_data.kind = ENT_INSIDE;
      end else begin
         q_data.kind = ENT_OUTSIDE;
      end
   end

endmodule
`default_nettype wire

FILE: sv/gpfl_queue.sv
// Short FIFO of classified entries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module gpfl_queue import gpfl_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  entry_type  din,
   input  wire logic  pop,
   output entry_type  dout,
   output q_status_type stat
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign stat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign dout       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_W'(1);
         if (push && !pop) begin
            cnt_ff <= cnt_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - (QPTR_W+1)'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/gpfl_back.sv
// Back end: pixel memory, 3x3 stencil accumulation, divide by 12 and force scaling.
`timescale 1ns / 1ps
`default_nettype none
module gpfl_back import gpfl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  entry_type              q_head,
   input  q_status_type           q_stat,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DATA_W-1:0]      rsp_potential,
   output logic [DATA_W-1:0]      rsp_force_x,
   output logic [DATA_W-1:0]      rsp_force_y,
   output logic                   rsp_inside_res
);

   bk_state_type st_ff, st_in;

   logic [DATA_W-1:0] mem [MAX_COLS*MAX_ROWS];

   logic                     inside_ff;
   logic [COL_W-1:0]         ix_ff;
   logic [ROW_W-1:0]         iy_ff;
   logic signed [FRAC_W-1:0] fx_ff, fy_ff;
   logic [3:0]               tap_ff;
   logic [1:0]               dc_ff, dr_ff;
   logic                     rd_vld_ff, mul_vld_ff;
   logic [3:0]               rd_tap_ff;
   logic signed [DATA_W-1:0] rdata_ff, pot_ff;
   logic signed [TAP_PROD_W-1:0] pw_x_ff, pw_y_ff;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff;
   logic [NUM_W-1:0]         num_x_ff, num_y_ff;
   logic [1:0]               rem_x_ff, rem_y_ff;
   logic [2:0]               div_cnt_ff;
   logic signed [PLO_W-1:0]  plo_x_ff, plo_y_ff;
   logic signed [PHI_W-1:0]  phi_x_ff, phi_y_ff;
   logic signed [DATA_W-1:0] force_x_ff, force_y_ff;
   logic                     rsp_valid_ff, rsp_in_ff;
   logic [DATA_W-1:0]        rsp_pot_ff, rsp_fx_ff, rsp_fy_ff;

   logic q_pop_w, mem_we, start, issue, div_load, div_step, scale_a, scale_b, out_load;
   logic drained, out_free;
   logic [ADDR_W-1:0]        mem_addr, tap_addr;
   logic [COL_W-1:0]         tap_col;
   logic [ROW_W-1:0]         tap_row;
   logic signed [WGT_W-1:0]  fxe, fye, fx3, fx4, fx8, fy3, fy4, fy8, w_x, w_y;
   logic signed [ACC_W-1:0]  neg_x, neg_y;
   logic [NUM_W-1:0]         n_x, n_y;
   logic [NUM_W-1:0]         n_bias;
   logic [T_W-1:0]           t_bias;
   logic [DIV_BITS+1:0]      dv_x, dv_y;
   logic signed [T_W-1:0]    t_x, t_y;
   logic signed [FRC_W-1:0]  r_x, r_y;
   logic signed [WGT_W-1:0]  two_q;

   assign two_q  = WGT_W'(2 << FRAC_W);
   assign n_bias = NUM_W'(3) << (A_W - 1);
   assign t_bias = T_W'(1) << (A_W - 1);

   assign drained  = !rd_vld_ff && !mul_vld_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               case (q_head.kind)
                  ENT_INSIDE:  st_in = BK_READ;
                  ENT_OUTSIDE: st_in = BK_OUT;
                  default:     st_in = BK_IDLE;
               endcase
            end
         end
         BK_READ:    if (tap_ff == 4'(NUM_TAPS - 1)) st_in = BK_DRAIN;
         BK_DRAIN:   if (drained) st_in = BK_DIV;
         BK_DIV:     if (div_cnt_ff == 3'(DIV_STEPS - 1)) st_in = BK_SCALE_A;
         BK_SCALE_A: st_in = BK_SCALE_B;
         BK_SCALE_B: st_in = BK_OUT;
         BK_OUT:     if (out_free) st_in = BK_IDLE;
         default:    st_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop_w  = (st_ff == BK_IDLE) && !q_stat.empty;
      mem_we   = q_pop_w && (q_head.kind == ENT_WRITE);
      start    = q_pop_w && (q_head.kind == ENT_INSIDE);
      issue    = (st_ff == BK_READ);
      div_load = (st_ff == BK_DRAIN) && drained;
      div_step = (st_ff == BK_DIV);
      scale_a  = (st_ff == BK_SCALE_A);
      scale_b  = (st_ff == BK_SCALE_B);
      out_load = (st_ff == BK_OUT) && out_free;
   end

   assign q_pop = q_pop_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= BK_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         rd_vld_ff  <= issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   // Entry capture and tap walk.
   always_ff @(posedge clock) begin
      if (q_pop_w) begin
         inside_ff <= (q_head.kind == ENT_INSIDE);
         ix_ff     <= q_head.ix;
         iy_ff     <= q_head.iy;
         fx_ff     <= q_head.fx;
         fy_ff     <= q_head.fy;
      end
      if (start) begin
         tap_ff <= '0;
         dc_ff  <= '0;
         dr_ff  <= '0;
      end else if (issue) begin
         tap_ff <= tap_ff + 4'(1);
         if (dc_ff == 2'd2) begin
            dc_ff <= '0;
            dr_ff <= dr_ff + 2'(1);
         end else begin
            dc_ff <= dc_ff + 2'(1);
         end
      end
   end

   assign tap_col  = ix_ff + COL_W'(dc_ff) - COL_W'(1);
   assign tap_row  = iy_ff + ROW_W'(dr_ff) - ROW_W'(1);
   assign tap_addr = ADDR_W'(tap_row) * ADDR_W'(MAX_COLS) + ADDR_W'(tap_col);
   assign mem_addr = mem_we ? q_head.addr : tap_addr;

   // Single-port pixel memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= q_head.wdata;
      end
      rdata_ff  <= mem[mem_addr];
      rd_tap_ff <= tap_ff;
   end

   // Stencil weights for the tap whose pixel is in rdata_ff.
   assign fxe = WGT_W'(fx_ff);
   assign fye = WGT_W'(fy_ff);
   assign fx4 = fxe <<< 2;
   assign fx8 = fxe <<< 3;
   assign fx3 = (fxe <<< 1) + fxe;
   assign fy4 = fye <<< 2;
   assign fy8 = fye <<< 3;
   assign fy3 = (fye <<< 1) + fye;

   always_comb begin
      case (rd_tap_ff)
         4'd0: begin w_x = -two_q + fx4 + fy3; w_y = -two_q + fx3 + fy4; end
         4'd1: begin w_x = -fx8;               w_y = -two_q + fy4;       end
         4'd2: begin w_x = two_q + fx4 - fy3;  w_y = -two_q - fx3 + fy4; end
         4'd3: begin w_x = -two_q + fx4;       w_y = -fy8;               end
         4'd4: begin w_x = -fx8;               w_y = -fy8;               end
         4'd5: begin w_x = two_q + fx4;        w_y = -fy8;               end
         4'd6: begin w_x = -two_q + fx4 - fy3; w_y = two_q - fx3 + fy4;  end
         4'd7: begin w_x = -fx8;               w_y = two_q + fy4;        end
         4'd8: begin w_x = two_q + fx4 + fy3;  w_y = two_q + fx3 + fy4;  end
         default: begin w_x = '0;              w_y = '0;                 end
      endcase
   end

   always_ff @(posedge clock) begin
      pw_x_ff <= w_x * rdata_ff;
      pw_y_ff <= w_y * rdata_ff;
      if (rd_vld_ff && (rd_tap_ff == 4'(CENTER_TAP))) begin
         pot_ff <= rdata_ff;
      end
      if (start) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_x_ff <= acc_x_ff + ACC_W'(pw_x_ff);
         acc_y_ff <= acc_y_ff + ACC_W'(pw_y_ff);
      end
   end

   // floor(-S / (3 * 2^18)): shift, bias to positive, then divide by three.
   assign neg_x = -acc_x_ff;
   assign neg_y = -acc_y_ff;
   assign n_x   = NUM_W'($signed(neg_x[ACC_W-1:DIV_SHIFT])) + n_bias;
   assign n_y   = NUM_W'($signed(neg_y[ACC_W-1:DIV_SHIFT])) + n_bias;

   function automatic logic [DIV_BITS+1:0] div3_step(input logic [1:0] r_in,
                                                     input logic [DIV_BITS-1:0] b);
      logic [2:0]          t;
      logic [1:0]          r;
      logic [DIV_BITS-1:0] q;
      r = r_in;
      q = '0;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         t = {r, b[i]};
         if (t >= 3'd3) begin
            t    = t - 3'd3;
            q[i] = 1'b1;
         end
         r = t[1:0];
      end
      div3_step = {r, q};
   endfunction

   assign dv_x = div3_step(rem_x_ff, num_x_ff[NUM_W-1 -: DIV_BITS]);
   assign dv_y = div3_step(rem_y_ff, num_y_ff[NUM_W-1 -: DIV_BITS]);

   always_ff @(posedge clock) begin
      if (div_load) begin
         num_x_ff   <= n_x;
         num_y_ff   <= n_y;
         rem_x_ff   <= '0;
         rem_y_ff   <= '0;
         div_cnt_ff <= '0;
      end else if (div_step) begin
         num_x_ff   <= {num_x_ff[NUM_W-DIV_BITS-1:0], dv_x[DIV_BITS-1:0]};
         num_y_ff   <= {num_y_ff[NUM_W-DIV_BITS-1:0], dv_y[DIV_BITS-1:0]};
         rem_x_ff   <= dv_x[DIV_BITS+1:DIV_BITS];
         rem_y_ff   <= dv_y[DIV_BITS+1:DIV_BITS];
         div_cnt_ff <= div_cnt_ff + 3'(1);
      end
   end

   // T * inv / 2^16 split into low and high partial products.
   assign t_x = $signed(num_x_ff[T_W-1:0] - t_bias);
   assign t_y = $signed(num_y_ff[T_W-1:0] - t_bias);
   assign r_x = FRC_W'(phi_x_ff) + FRC_W'($signed(plo_x_ff[PLO_W-1:FRAC_W]));
   assign r_y = FRC_W'(phi_y_ff) + FRC_W'($signed(plo_y_ff[PLO_W-1:FRAC_W]));

   always_ff @(posedge clock) begin
      if (scale_a) begin
         plo_x_ff <= $signed({1'b0, t_x[FRAC_W-1:0]}) * cfg.inv_x;
         plo_y_ff <= $signed({1'b0, t_y[FRAC_W-1:0]}) * cfg.inv_y;
         phi_x_ff <= $signed(t_x[T_W-1:FRAC_W]) * cfg.inv_x;
         phi_y_ff <= $signed(t_y[T_W-1:FRAC_W]) * cfg.inv_y;
      end
      if (scale_b) begin
         force_x_ff <= sat32(64'(r_x));
         force_y_ff <= sat32(64'(r_y));
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_in_ff  <= inside_ff;
         rsp_pot_ff <= inside_ff ? pot_ff : '0;
         rsp_fx_ff  <= inside_ff ? force_x_ff : '0;
         rsp_fy_ff  <= inside_ff ? force_y_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_potential  = rsp_pot_ff;
   assign rsp_force_x    = rsp_fx_ff;
   assign rsp_force_y    = rsp_fy_ff;
   assign rsp_inside_res = rsp_in_ff;

`ifndef SYNTHESIS
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_READ) |-> (tap_ff <= 4'(NUM_TAPS - 1)))
      else $error("tap counter ran past the stencil");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (st_ff == BK_IDLE) && !issue)
      else $error("pixel write collides with a stencil read");

   a_div_drained: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_DIV) |-> (!rd_vld_ff && !mul_vld_ff))
      else $error("divide started before accumulation finished");
`endif

endmodule
`default_nettype wire

FILE: sv/grid_potential_force_lookup_core.sv
// Top level of the grid potential force lookup block.
// Input channel (req_*): one beat per item. req_cmd = 0 stores req_pixel_value,
// scaled by value_scale and saturated, at (req_col, req_row); req_cmd = 1
// queries the position (req_pos_x, req_pos_y). Writes give no result.
// Result channel (rsp_*): one beat per query with potential, force_x,
// force_y and inside_res; queries outside the border band return zeros.
// The front stage steps each item through accept, multiply and classify and
// takes no new item until it has pushed the last one into a 4-entry queue.
// The back stage retires a write as it pops it; a query takes 9 reads of the
// single-port pixel memory (one per cycle), a multiply-accumulate drain, the
// divide-by-three unit and force scaling, then the output register.
// A stalled receiver holds the result in the output register; the back stalls
// behind it while the front keeps filling the queue, then req_ready drops.
// Synchronous reset clears the control state and loads the register defaults;
// the pixel memory holds no reset value and needs no clearing pass: write each
// pixel before any query reads it. Configure only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module grid_potential_force_lookup_core import gpfl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [7:0]         req_col,
   input  wire logic [7:0]         req_row,
   input  wire logic [DATA_W-1:0]  req_pixel_value,
   input  wire logic [DATA_W-1:0]  req_pos_x,
   input  wire logic [DATA_W-1:0]  req_pos_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [DATA_W-1:0]       rsp_potential,
   output logic [DATA_W-1:0]       rsp_force_x,
   output logic [DATA_W-1:0]       rsp_force_y,
   output logic                    rsp_inside_res,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   cfg_type      cfg;
   q_status_type q_stat;
   entry_type    q_in, q_head;
   logic         q_push, q_pop;

   // Register file never waits.
   assign pready = 1'b1;

   gpfl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // Front: accept, scale writes, locate queries and classify them.
   gpfl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_pixel_value (req_pixel_value),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_data          (q_in)
   );

   // Decouple the two halves so either can stall alone.
   gpfl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in),
      .pop   (q_pop),
      .dout  (q_head),
      .stat  (q_stat)
   );

   // Back: pixel memory, stencil sum, divide and force scaling.
   gpfl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_head         (q_head),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_potential  (rsp_potential),
      .rsp_force_x    (rsp_force_x),
      .rsp_force_y    (rsp_force_y),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule
`default_nettype wire
